### sv/hashed_allocation_tracker_assert.svh
// Assertion macros shared by the hashed allocation tracker RTL.
// Depends on nothing; included by the top level only.
`ifndef HASHED_ALLOCATION_TRACKER_ASSERT_SVH
`define HASHED_ALLOCATION_TRACKER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HAT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hat assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define HAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hat assertion failed");

`endif

### sv/hat_pkg.sv
// Shared types and constants of the hashed allocation tracker.
// Depends on nothing; used by every module of the block but hat_queue.
package hat_pkg;

   localparam int ADDR_W   = 64;
   localparam int SIZE_W   = 32;
   localparam int TOTAL_W  = 48;
   localparam int RBYTES_W = 36;
   localparam int RCOUNT_W = 4;

   localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
   localparam int SHIFT_A = 30;
   localparam int SHIFT_B = 27;
   localparam int SHIFT_C = 31;

   // The remainder unit takes this many bits of the hash per cycle.
   localparam int MOD_STEP  = 4;
   localparam int MOD_COUNT = ADDR_W / MOD_STEP;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = {TOTAL_W{1'b1}};
   localparam logic [RBYTES_W-1:0] RBYTES_MAX = {RBYTES_W{1'b1}};
   localparam logic [RCOUNT_W-1:0] RCOUNT_MAX = {RCOUNT_W{1'b1}};

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_DROPPED   = 2'd1,
      ST_REMOVED   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_MOD,
      F_OUT
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_READ,
      B_LOAD,
      B_SCAN,
      B_WRITE,
      B_DONE
   } back_state_type;

endpackage

### sv/hat_front.sv
// Front end: accepts requests and hashes the address to a bucket.
// Depends on hat_pkg; feeds hat_queue.
module hat_front #(
   parameter int BUCKETS = 256,
   parameter int BKT_W   = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       hold,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic                       in_operation,
   input  logic [hat_pkg::ADDR_W-1:0] in_address,
   input  logic [hat_pkg::SIZE_W-1:0] in_block_size,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic                       out_operation,
   output logic [hat_pkg::ADDR_W-1:0] out_address,
   output logic [hat_pkg::SIZE_W-1:0] out_block_size,
   output logic [BKT_W-1:0]           out_bucket
);

   localparam bit POW2 = ((1 << BKT_W) == BUCKETS);
   localparam int DIG_W = $clog2(hat_pkg::MOD_COUNT);

   hat_pkg::front_state_type state_ff, state_in;

   logic                       op_ff;
   logic [hat_pkg::ADDR_W-1:0] addr_ff;
   logic [hat_pkg::SIZE_W-1:0] size_ff;
   logic [63:0]                z_ff;
   logic [63:0]                acc_ff;
   logic [1:0]                 part_ff;
   logic                       round_ff;
   logic [BKT_W-1:0]           rem_ff;
   logic [DIG_W-1:0]           dig_ff;

   logic [63:0] mul_const;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] prod;
   logic [63:0] acc_sum;
   logic [BKT_W-1:0] rem_next;
   logic accept;

   assign accept = in_valid && in_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hat_pkg::F_IDLE: begin
            if (accept) state_in = hat_pkg::F_MUL;
         end
         hat_pkg::F_MUL: begin
            if (round_ff && part_ff == 2'd2) state_in = POW2 ? hat_pkg::F_OUT : hat_pkg::F_MOD;
         end
         hat_pkg::F_MOD: begin
            if (dig_ff == DIG_W'(hat_pkg::MOD_COUNT - 1)) state_in = hat_pkg::F_OUT;
         end
         hat_pkg::F_OUT: begin
            if (out_ready) state_in = hat_pkg::F_IDLE;
         end
         default: state_in = hat_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      in_ready  = (state_ff == hat_pkg::F_IDLE) && !hold;
      out_valid = (state_ff == hat_pkg::F_OUT);
   end

   always_comb begin
      mul_const = round_ff ? hat_pkg::MIX_C2 : hat_pkg::MIX_C1;
      mul_a = (part_ff == 2'd1) ? z_ff[63:32] : z_ff[31:0];
      mul_b = (part_ff == 2'd2) ? mul_const[63:32] : mul_const[31:0];
      prod  = 64'(mul_a) * 64'(mul_b);
      acc_sum = (part_ff == 2'd0) ? prod : acc_ff + {prod[31:0], 32'd0};
   end

   always_comb begin
      logic [BKT_W:0] t;
      logic [BKT_W-1:0] r;
      r = rem_ff;
      for (int i = 0; i < hat_pkg::MOD_STEP; i++) begin
         t = {r, z_ff[63-i]};
         if (t >= (BKT_W+1)'(BUCKETS)) t = t - (BKT_W+1)'(BUCKETS);
         r = t[BKT_W-1:0];
      end
      rem_next = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hat_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         hat_pkg::F_IDLE: begin
            if (accept) begin
               op_ff    <= in_operation;
               addr_ff  <= in_address;
               size_ff  <= in_block_size;
               z_ff     <= in_address ^ (in_address >> hat_pkg::SHIFT_A);
               part_ff  <= 2'd0;
               round_ff <= 1'b0;
            end
         end
         hat_pkg::F_MUL: begin
            acc_ff <= acc_sum;
            if (part_ff == 2'd2) begin
               part_ff  <= 2'd0;
               round_ff <= 1'b1;
               rem_ff   <= '0;
               dig_ff   <= '0;
               if (round_ff) z_ff <= acc_sum ^ (acc_sum >> hat_pkg::SHIFT_C);
               else z_ff <= acc_sum ^ (acc_sum >> hat_pkg::SHIFT_B);
            end else begin
               part_ff <= part_ff + 2'd1;
            end
         end
         hat_pkg::F_MOD: begin
            rem_ff <= rem_next;
            z_ff   <= z_ff << hat_pkg::MOD_STEP;
            dig_ff <= dig_ff + DIG_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign out_operation  = op_ff;
   assign out_address    = addr_ff;
   assign out_block_size = size_ff;
   assign out_bucket     = POW2 ? z_ff[BKT_W-1:0] : rem_ff;

endmodule

### sv/hat_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on nothing beyond its width parameter.
module hat_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = data_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) data_ff[wr_ptr_ff] <= in_data;
   end

endmodule

### sv/hat_back.sv
// Back end: entry store, generation byte totals and the result register.
// Depends on hat_pkg; takes requests from hat_queue.
module hat_back #(
   parameter int BUCKETS          = 256,
   parameter int GENERATION_COUNT = 3,
   parameter int WAYS             = 4,
   parameter int BKT_W            = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   output logic                         clearing,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_operation,
   input  logic [hat_pkg::ADDR_W-1:0]   in_address,
   input  logic [hat_pkg::SIZE_W-1:0]   in_block_size,
   input  logic [BKT_W-1:0]             in_bucket,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [1:0]                   out_status,
   output logic [hat_pkg::RCOUNT_W-1:0] out_removed_count,
   output logic [hat_pkg::RBYTES_W-1:0] out_removed_bytes,
   output logic [hat_pkg::TOTAL_W-1:0]  out_young_total_bytes
);

   localparam int ROWS  = GENERATION_COUNT * BUCKETS;
   localparam int ROW_W = $clog2(ROWS);
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int GEN_W = (GENERATION_COUNT > 1) ? $clog2(GENERATION_COUNT) : 1;
   localparam int AW = hat_pkg::ADDR_W;
   localparam int SW = hat_pkg::SIZE_W;
   localparam int TW = hat_pkg::TOTAL_W;
   localparam int CW = hat_pkg::RCOUNT_W;

   logic [WAYS-1:0]         mem_valid [ROWS];
   logic [WAYS-1:0][AW-1:0] mem_addr  [ROWS];
   logic [WAYS-1:0][SW-1:0] mem_size  [ROWS];

   hat_pkg::back_state_type state_ff, state_in;

   logic [WAYS-1:0]         rd_valid_ff;
   logic [WAYS-1:0][AW-1:0] rd_addr_ff;
   logic [WAYS-1:0][SW-1:0] rd_size_ff;
   logic [WAYS-1:0]         row_valid_ff;
   logic [WAYS-1:0][AW-1:0] row_addr_ff;
   logic [WAYS-1:0][SW-1:0] row_size_ff;

   logic                         op_ff;
   logic [AW-1:0]                addr_ff;
   logic [SW-1:0]                size_ff;
   logic [BKT_W-1:0]             bucket_ff;
   logic [GEN_W-1:0]             gen_ff;
   logic [WAY_W-1:0]             way_ff;
   logic [ROW_W-1:0]             clr_row_ff;
   logic [hat_pkg::RCOUNT_W-1:0] rcount_ff;
   logic [hat_pkg::RBYTES_W-1:0] rbytes_ff;
   hat_pkg::status_type          status_ff;
   logic [TW-1:0]                gen_bytes_ff [GENERATION_COUNT];

   logic                         rsp_valid_ff;
   hat_pkg::status_type          rsp_status_ff;
   logic [hat_pkg::RCOUNT_W-1:0] rsp_rcount_ff;
   logic [hat_pkg::RBYTES_W-1:0] rsp_rbytes_ff;
   logic [TW-1:0]                rsp_young_ff;

   logic [ROW_W-1:0]        row_sel;
   logic                    mem_we;
   logic [ROW_W-1:0]        mem_waddr;
   logic [WAYS-1:0]         mem_wvalid;
   logic [WAYS-1:0][AW-1:0] mem_waddr_data;
   logic [WAYS-1:0][SW-1:0] mem_wsize;

   logic             free_any;
   logic [WAY_W-1:0] free_way;
   logic             hit;
   logic [SW-1:0]    hit_size;
   logic [TW-1:0]    gen_sel;
   logic [TW-1:0]    gen_sub;
   logic [TW:0]      ins_sum;
   logic [hat_pkg::RBYTES_W:0] rbytes_sum;

   assign row_sel = ROW_W'(ROW_W'(gen_ff) * ROW_W'(BUCKETS) + ROW_W'(bucket_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hat_pkg::B_CLEAR: begin
            if (clr_row_ff == ROW_W'(ROWS - 1)) state_in = hat_pkg::B_IDLE;
         end
         hat_pkg::B_IDLE: begin
            if (in_valid && !rsp_valid_ff) state_in = hat_pkg::B_READ;
         end
         hat_pkg::B_READ: state_in = hat_pkg::B_LOAD;
         hat_pkg::B_LOAD: begin
            state_in = (op_ff == hat_pkg::OP_INSERT) ? hat_pkg::B_DONE : hat_pkg::B_SCAN;
         end
         hat_pkg::B_SCAN: begin
            if (way_ff == WAY_W'(WAYS - 1)) state_in = hat_pkg::B_WRITE;
         end
         hat_pkg::B_WRITE: begin
            if (gen_ff == GEN_W'(GENERATION_COUNT - 1)) state_in = hat_pkg::B_DONE;
            else state_in = hat_pkg::B_READ;
         end
         hat_pkg::B_DONE: state_in = hat_pkg::B_IDLE;
         default: state_in = hat_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      free_any = 1'b0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!rd_valid_ff[w]) begin
            free_any = 1'b1;
            free_way = WAY_W'(w);
         end
      end
   end

   always_comb begin
      hit      = row_valid_ff[way_ff] && (row_addr_ff[way_ff] == addr_ff);
      hit_size = row_size_ff[way_ff];
      gen_sel  = gen_bytes_ff[gen_ff];
      gen_sub  = (gen_sel >= TW'(hit_size)) ? gen_sel - TW'(hit_size) : '0;
      ins_sum  = {1'b0, gen_bytes_ff[0]} + (TW+1)'(size_ff);
      rbytes_sum = {1'b0, rbytes_ff} + (hat_pkg::RBYTES_W+1)'(hit_size);
   end

   always_comb begin
      clearing       = (state_ff == hat_pkg::B_CLEAR);
      in_ready       = (state_ff == hat_pkg::B_IDLE) && !rsp_valid_ff;
      mem_we         = 1'b0;
      mem_waddr      = row_sel;
      mem_wvalid     = row_valid_ff;
      mem_waddr_data = row_addr_ff;
      mem_wsize      = row_size_ff;
      case (state_ff)
         hat_pkg::B_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_row_ff;
            mem_wvalid = '0;
         end
         hat_pkg::B_LOAD: begin
            mem_wvalid     = rd_valid_ff;
            mem_waddr_data = rd_addr_ff;
            mem_wsize      = rd_size_ff;
            mem_wvalid[free_way]     = 1'b1;
            mem_waddr_data[free_way] = addr_ff;
            mem_wsize[free_way]      = size_ff;
            mem_we = (op_ff == hat_pkg::OP_INSERT) && free_any;
         end
         hat_pkg::B_WRITE: mem_we = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_valid[mem_waddr] <= mem_wvalid;
         mem_addr[mem_waddr]  <= mem_waddr_data;
         mem_size[mem_waddr]  <= mem_wsize;
      end
      rd_valid_ff <= mem_valid[row_sel];
      rd_addr_ff  <= mem_addr[row_sel];
      rd_size_ff  <= mem_size[row_sel];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hat_pkg::B_CLEAR;
         clr_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < GENERATION_COUNT; g++) gen_bytes_ff[g] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == hat_pkg::B_CLEAR) clr_row_ff <= clr_row_ff + ROW_W'(1);
         if (rsp_valid_ff && out_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            hat_pkg::B_LOAD: begin
               if (op_ff == hat_pkg::OP_INSERT && free_any) begin
                  gen_bytes_ff[0] <= ins_sum[TW] ? hat_pkg::TOTAL_MAX : ins_sum[TW-1:0];
               end
            end
            hat_pkg::B_SCAN: begin
               if (hit) gen_bytes_ff[gen_ff] <= gen_sub;
            end
            hat_pkg::B_DONE: rsp_valid_ff <= 1'b1;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         hat_pkg::B_IDLE: begin
            if (in_valid && !rsp_valid_ff) begin
               op_ff     <= in_operation;
               addr_ff   <= in_address;
               size_ff   <= in_block_size;
               bucket_ff <= in_bucket;
               gen_ff    <= '0;
               rcount_ff <= '0;
               rbytes_ff <= '0;
            end
         end
         hat_pkg::B_LOAD: begin
            row_valid_ff <= rd_valid_ff;
            row_addr_ff  <= rd_addr_ff;
            row_size_ff  <= rd_size_ff;
            way_ff       <= '0;
            status_ff    <= free_any ? hat_pkg::ST_INSERTED : hat_pkg::ST_DROPPED;
         end
         hat_pkg::B_SCAN: begin
            way_ff <= way_ff + WAY_W'(1);
            if (hit) begin
               row_valid_ff[way_ff] <= 1'b0;
               if (rcount_ff != hat_pkg::RCOUNT_MAX) rcount_ff <= rcount_ff + CW'(1);
               rbytes_ff <= rbytes_sum[hat_pkg::RBYTES_W] ? hat_pkg::RBYTES_MAX
                                                           : rbytes_sum[hat_pkg::RBYTES_W-1:0];
            end
         end
         hat_pkg::B_WRITE: gen_ff <= gen_ff + GEN_W'(1);
         hat_pkg::B_DONE: begin
            rsp_rcount_ff <= rcount_ff;
            rsp_rbytes_ff <= rbytes_ff;
            rsp_young_ff  <= gen_bytes_ff[0];
            if (op_ff == hat_pkg::OP_INSERT) rsp_status_ff <= status_ff;
            else if (rcount_ff != '0) rsp_status_ff <= hat_pkg::ST_REMOVED;
            else rsp_status_ff <= hat_pkg::ST_NOT_FOUND;
         end
         default: begin
         end
      endcase
   end

   assign out_valid             = rsp_valid_ff;
   assign out_status            = rsp_status_ff;
   assign out_removed_count     = rsp_rcount_ff;
   assign out_removed_bytes     = rsp_rbytes_ff;
   assign out_young_total_bytes = rsp_young_ff;

endmodule

### sv/hashed_allocation_tracker.sv
// Top level of the hashed allocation tracker: front end, queue and back end.
// Depends on hat_pkg, hat_front, hat_queue, hat_back and the assertion header.
//
//   channel  handshake              payload
//   req      req_valid/req_ready    operation, address, block_size
//   rsp      rsp_valid/rsp_ready    status, removed_count, removed_bytes, young_total_bytes
//
// The front end hashes with one shared 32x32 multiplier, plus remainder steps when
// BUCKETS is not a power of two. In the back end an insert passes READ, LOAD and DONE;
// a remove repeats READ, LOAD, SCAN and WRITE for each generation, bounded by the entry
// store, read one row at a time, and one way compared per cycle. After reset the store
// is cleared one row a cycle, all GENERATION_COUNT*BUCKETS rows, while req_ready is low.
// A queue of two requests lets the hash of the next request overlap the store work; a
// held response stalls the back end, and the front end once the queue is full.
`include "hashed_allocation_tracker_assert.svh"

module hashed_allocation_tracker #(
   parameter int BUCKETS          = 256,
   parameter int GENERATION_COUNT = 3,
   parameter int WAYS             = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [hat_pkg::ADDR_W-1:0]   req_address,
   input  logic [hat_pkg::SIZE_W-1:0]   req_block_size,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [hat_pkg::RCOUNT_W-1:0] rsp_removed_count,
   output logic [hat_pkg::RBYTES_W-1:0] rsp_removed_bytes,
   output logic [hat_pkg::TOTAL_W-1:0]  rsp_young_total_bytes
);

   localparam int BKT_W = $clog2(BUCKETS);
   localparam int QW = 1 + hat_pkg::ADDR_W + hat_pkg::SIZE_W + BKT_W;

   logic                       clearing;
   logic                       f_valid, f_ready, f_op;
   logic [hat_pkg::ADDR_W-1:0] f_addr;
   logic [hat_pkg::SIZE_W-1:0] f_size;
   logic [BKT_W-1:0]           f_bucket;
   logic                       q_valid, q_ready;
   logic [QW-1:0]              q_data;

   hat_front #(.BUCKETS(BUCKETS), .BKT_W(BKT_W)) u_front (
      .clock(clock), .reset(reset), .hold(clearing),
      .in_valid(req_valid), .in_ready(req_ready), .in_operation(req_operation),
      .in_address(req_address), .in_block_size(req_block_size),
      .out_valid(f_valid), .out_ready(f_ready), .out_operation(f_op),
      .out_address(f_addr), .out_block_size(f_size), .out_bucket(f_bucket)
   );

   hat_queue #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data({f_op, f_addr, f_size, f_bucket}),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   hat_back #(
      .BUCKETS(BUCKETS), .GENERATION_COUNT(GENERATION_COUNT), .WAYS(WAYS), .BKT_W(BKT_W)
   ) u_back (
      .clock(clock), .reset(reset), .clearing(clearing),
      .in_valid(q_valid), .in_ready(q_ready),
      .in_operation(q_data[QW-1]),
      .in_address(q_data[QW-2 -: hat_pkg::ADDR_W]),
      .in_block_size(q_data[BKT_W +: hat_pkg::SIZE_W]),
      .in_bucket(q_data[BKT_W-1:0]),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_status(rsp_status),
      .out_removed_count(rsp_removed_count), .out_removed_bytes(rsp_removed_bytes),
      .out_young_total_bytes(rsp_young_total_bytes)
   );

   `HAT_ASSERT_SAME(a_no_accept_in_clear, clock, reset, clearing, !req_ready)
   `HAT_ASSERT_SAME(a_insert_removes_none, clock, reset,
      rsp_valid && (rsp_status == hat_pkg::ST_INSERTED || rsp_status == hat_pkg::ST_DROPPED),
      rsp_removed_count == '0 && rsp_removed_bytes == '0)
   `HAT_ASSERT_SAME(a_remove_count_matches, clock, reset,
      rsp_valid && rsp_status == hat_pkg::ST_REMOVED, rsp_removed_count != '0)
   `HAT_ASSERT_NEXT(a_queue_holds_front, clock, reset,
      f_valid && !f_ready, f_valid)

endmodule

### sim/hat_checker.sv
// Bucket hash helper and scoreboard checker for the hashed allocation tracker.
// Depends on hat_pkg; watches the request and response channels of the block.
package hat_tb_pkg;

   localparam int TB_BUCKETS = 256;
   localparam int TB_GENS    = 3;
   localparam int TB_WAYS    = 4;

   function automatic int unsigned bucket_hash(input logic [63:0] a);
      logic [63:0] z;
      z = a;
      z = (z ^ (z >> hat_pkg::SHIFT_A)) * hat_pkg::MIX_C1;
      z = (z ^ (z >> hat_pkg::SHIFT_B)) * hat_pkg::MIX_C2;
      z = z ^ (z >> hat_pkg::SHIFT_C);
      return int'(z % 64'(TB_BUCKETS));
   endfunction

endpackage

module hat_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_operation,
   input  logic [hat_pkg::ADDR_W-1:0]   req_address,
   input  logic [hat_pkg::SIZE_W-1:0]   req_block_size,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [1:0]                   rsp_status,
   input  logic [hat_pkg::RCOUNT_W-1:0] rsp_removed_count,
   input  logic [hat_pkg::RBYTES_W-1:0] rsp_removed_bytes,
   input  logic [hat_pkg::TOTAL_W-1:0]  rsp_young_total_bytes,
   output int                           fail_count,
   output int                           pending
);

   localparam int GENS    = hat_tb_pkg::TB_GENS;
   localparam int BUCKETS = hat_tb_pkg::TB_BUCKETS;
   localparam int WAYS    = hat_tb_pkg::TB_WAYS;
   localparam int TW      = hat_pkg::TOTAL_W;
   localparam int RW      = hat_pkg::RBYTES_W;

   typedef struct {
      hat_pkg::status_type          status;
      logic [hat_pkg::RCOUNT_W-1:0] count;
      logic [RW-1:0]                bytes;
      logic [TW-1:0]                total;
   } outcome_type;

   logic                       live  [GENS][BUCKETS][WAYS];
   logic [hat_pkg::ADDR_W-1:0] keys  [GENS][BUCKETS][WAYS];
   logic [hat_pkg::SIZE_W-1:0] sizes [GENS][BUCKETS][WAYS];
   logic [TW-1:0]              gen_bytes [GENS];
   outcome_type                outcome_q [$];

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("tb: mismatch %s got %0h expected %0h", what, got, want);
      fail_count++;
   endtask

   function automatic outcome_type track_request(input logic op, input logic [63:0] a,
                                                 input logic [31:0] sz);
      outcome_type o;
      int unsigned b;
      logic [TW:0] sum;
      logic [RW:0] rb;
      b = hat_tb_pkg::bucket_hash(a);
      o.count = '0;
      o.bytes = '0;
      if (op == hat_pkg::OP_INSERT) begin
         o.status = hat_pkg::ST_DROPPED;
         for (int w = 0; w < WAYS; w++) begin
            if (!live[0][b][w]) begin
               live[0][b][w] = 1'b1;
               keys[0][b][w] = a;
               sizes[0][b][w] = sz;
               sum = {1'b0, gen_bytes[0]} + (TW+1)'(sz);
               gen_bytes[0] = sum[TW] ? hat_pkg::TOTAL_MAX : sum[TW-1:0];
               o.status = hat_pkg::ST_INSERTED;
               break;
            end
         end
      end else begin
         for (int g = 0; g < GENS; g++) begin
            for (int w = 0; w < WAYS; w++) begin
               if (live[g][b][w] && keys[g][b][w] == a) begin
                  live[g][b][w] = 1'b0;
                  gen_bytes[g] = (gen_bytes[g] >= TW'(sizes[g][b][w])) ?
                                 gen_bytes[g] - TW'(sizes[g][b][w]) : '0;
                  if (o.count != hat_pkg::RCOUNT_MAX) o.count++;
                  rb = {1'b0, o.bytes} + (RW+1)'(sizes[g][b][w]);
                  o.bytes = rb[RW] ? hat_pkg::RBYTES_MAX : rb[RW-1:0];
               end
            end
         end
         o.status = (o.count != 0) ? hat_pkg::ST_REMOVED : hat_pkg::ST_NOT_FOUND;
      end
      o.total = gen_bytes[0];
      return o;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int g = 0; g < GENS; g++) begin
            gen_bytes[g] = '0;
            for (int b = 0; b < BUCKETS; b++)
               for (int w = 0; w < WAYS; w++) live[g][b][w] = 1'b0;
         end
         outcome_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               report("response with no request outstanding", 64'(rsp_status), 64'd0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status != want.status)
                  report("status", 64'(rsp_status), 64'(want.status));
               if (rsp_removed_count != want.count)
                  report("removed_count", 64'(rsp_removed_count), 64'(want.count));
               if (rsp_removed_bytes != want.bytes)
                  report("removed_bytes", 64'(rsp_removed_bytes), 64'(want.bytes));
               if (rsp_young_total_bytes != want.total)
                  report("young_total_bytes", 64'(rsp_young_total_bytes), 64'(want.total));
            end
         end
         if (req_valid && req_ready)
            outcome_q.push_back(track_request(req_operation, req_address, req_block_size));
      end
      pending = outcome_q.size();
   end

endmodule

### sim/tb_hashed_allocation_tracker.sv
// Testbench top for the hashed allocation tracker: clock, reset and traffic.
// Depends on hat_pkg, hat_tb_pkg, hat_checker and the hashed_allocation_tracker RTL.
module tb_hashed_allocation_tracker;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_operation = hat_pkg::OP_INSERT;
   logic [hat_pkg::ADDR_W-1:0]   req_address = '0;
   logic [hat_pkg::SIZE_W-1:0]   req_block_size = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [1:0]                   rsp_status;
   logic [hat_pkg::RCOUNT_W-1:0] rsp_removed_count;
   logic [hat_pkg::RBYTES_W-1:0] rsp_removed_bytes;
   logic [hat_pkg::TOTAL_W-1:0]  rsp_young_total_bytes;
   int                           fail_count;
   int                           pending;
   bit                           steady = 1'b0;
   bit                           long_hold = 1'b0;
   logic [63:0]                  live_pool [$];
   int unsigned                  hot [8];

   always #2 clock = ~clock;

   hashed_allocation_tracker dut (.*);

   hat_checker u_checker (.*);

   always begin
      int w;
      @(negedge clock);
      forever begin
         w = long_hold ? 300 : (steady ? 0 : $urandom_range(0, 3));
         long_hold = 1'b0;
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   function automatic logic [63:0] address_in(input int unsigned b);
      logic [63:0] a;
      do a = {$urandom, $urandom}; while (hat_tb_pkg::bucket_hash(a) != b);
      return a;
   endfunction

   task automatic send(input logic op, input logic [63:0] a, input logic [31:0] sz);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_address <= a;
      req_block_size <= sz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (op == hat_pkg::OP_INSERT) live_pool.push_back(a);
      else live_pool = live_pool.find(x) with (x != a);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [63:0] a;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send(hat_pkg::OP_INSERT, 64'h0, 32'h0);
      send(hat_pkg::OP_INSERT, '1, '1);
      send(hat_pkg::OP_REMOVE, '1, '0);
      send(hat_pkg::OP_REMOVE, 64'h0, '1);
      send(hat_pkg::OP_REMOVE, 64'h0, 32'h0);
      a = address_in(17);
      for (int i = 0; i < 4; i++)
         send(hat_pkg::OP_INSERT, (i < 2) ? a : address_in(17), $urandom);
      send(hat_pkg::OP_INSERT, address_in(17), '1);
      send(hat_pkg::OP_REMOVE, a, $urandom);
      send(hat_pkg::OP_REMOVE, a, $urandom);
      send(hat_pkg::OP_INSERT, a, '1);
      drain();
      for (int i = 0; i < 8; i++) hot[i] = $urandom_range(0, hat_tb_pkg::TB_BUCKETS - 1);
      for (int n = 0; n < 450; n++) begin
         if (n == 150) begin
            drain();
            long_hold = 1'b1;
            steady = 1'b1;
         end
         if (n == 170) steady = 1'b0;
         if (n == 300) drain();
         if (n >= 300 && n < 330) steady = 1'b1;
         if (n == 330) steady = 1'b0;
         if ($urandom_range(0, 99) < 55) begin
            if ($urandom_range(0, 9) < 8) a = address_in(hot[$urandom_range(0, 7)]);
            else if (live_pool.size() != 0 && $urandom_range(0, 1) == 1)
               a = live_pool[$urandom_range(0, live_pool.size() - 1)];
            else a = {$urandom, $urandom};
            send(hat_pkg::OP_INSERT, a, $urandom);
         end else begin
            if (live_pool.size() != 0 && $urandom_range(0, 9) < 8)
               a = live_pool[$urandom_range(0, live_pool.size() - 1)];
            else a = {$urandom, $urandom};
            send(hat_pkg::OP_REMOVE, a, $urandom);
         end
      end
      drain();
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

endmodule
